### hw/rtl/lpht_pkg.sv
package lpht_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 34;
    localparam int PAY_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int SLOT_W     = 4;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HOME   = 6'b000010,
        S_PROBE  = 6'b000100,
        S_SEARCH = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // TABLE_SIZE is a power of two: home slot is the low key bits
    function automatic logic [IDX_W-1:0] home_of(input logic [KEY_W-1:0] k);
        return k[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, i};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

### hw/rtl/linear_probe_hash_table_unit.sv
// Linear-probing hash table, 16 slots of 34-bit key and 32-bit payload.
// Input channel (in_valid/in_ready) carries func, key, payload; output
// channel (out_valid/out_ready) carries status, slot, found_payload.
// One word in gives exactly one word out.
// Items run one at a time through a sequencer that reads one slot per
// cycle: in_ready is high only while the sequencer is idle.
// A zero key or unused func goes straight to the result. Insert reads
// the home slot, then walks a probe of N slots (at most 16). Delete
// searches, then shifts the following entries back. The single slot
// read port sets how long each walk takes.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver stalls, the following result is held in the
// sequencer until the output register frees.
// Reset (rst_n low, async) empties every slot, sets displace_mode to 1 and
// drops any pending result. cfg_wr_en writes displace_mode.
module linear_probe_hash_table_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lpht_pkg::FUNC_W-1:0]         func,
    input  logic [lpht_pkg::KEY_W-1:0]          key,
    input  logic [lpht_pkg::PAY_W-1:0]          payload,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lpht_pkg::STAT_W-1:0]         status,
    output logic [lpht_pkg::SLOT_W-1:0]         slot,
    output logic [lpht_pkg::PAY_W-1:0]          found_payload
);

    localparam int IDX_W = lpht_pkg::IDX_W;
    localparam int CNT_W = lpht_pkg::CNT_W;
    localparam int KEY_W = lpht_pkg::KEY_W;
    localparam int PAY_W = lpht_pkg::PAY_W;

    lpht_pkg::state_t state_reg, state_next;

    logic [lpht_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [PAY_W-1:0]            pay_reg, pay_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            hole_reg, hole_next;
    logic [IDX_W-1:0]            rslot_reg, rslot_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        disp_reg, disp_next;
    logic                        mode_reg;

    logic [lpht_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [lpht_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [PAY_W-1:0]            res_pay_reg, res_pay_next;

    logic                        out_valid_reg;
    logic [lpht_pkg::STAT_W-1:0] status_reg;
    logic [lpht_pkg::SLOT_W-1:0] slot_reg;
    logic [PAY_W-1:0]            found_payload_reg;

    logic [KEY_W-1:0] key_mem_reg [lpht_pkg::TABLE_SIZE];
    logic [PAY_W-1:0] pay_mem_reg [lpht_pkg::TABLE_SIZE];

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [KEY_W-1:0] mem_wkey;
    logic [PAY_W-1:0] mem_wpay;

    logic [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0] rd_pay;
    logic             rd_empty;
    logic             in_fire;
    logic             out_load;
    logic             last_probe;

    assign rd_key     = key_mem_reg[idx_reg];
    assign rd_pay     = pay_mem_reg[idx_reg];
    assign rd_empty   = (rd_key == '0);
    assign in_ready   = (state_reg == lpht_pkg::S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_load   = (state_reg == lpht_pkg::S_DONE) && (!out_valid_reg || out_ready);
    assign last_probe = (cnt_reg == CNT_W'(lpht_pkg::TABLE_SIZE - 1));

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        idx_next        = idx_reg;
        hole_next       = hole_reg;
        rslot_next      = rslot_reg;
        cnt_next        = cnt_reg;
        disp_next       = disp_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pay_next    = res_pay_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wkey        = key_reg;
        mem_wpay        = pay_reg;

        case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next       = func;
                    key_next        = key;
                    pay_next        = payload;
                    idx_next        = lpht_pkg::home_of(key);
                    cnt_next        = '0;
                    disp_next       = 1'b0;
                    res_status_next = lpht_pkg::STAT_MISS;
                    res_slot_next   = '0;
                    res_pay_next    = '0;
                    if (key == '0)
                        state_next = lpht_pkg::S_DONE;
                    else
                    begin
                        case (func)
                            lpht_pkg::FUNC_INSERT: state_next = lpht_pkg::S_HOME;
                            lpht_pkg::FUNC_SEARCH,
                            lpht_pkg::FUNC_DELETE: state_next = lpht_pkg::S_SEARCH;
                            default:               state_next = lpht_pkg::S_DONE;
                        endcase
                    end
                end
            end

            lpht_pkg::S_HOME:
            begin
                if (rd_empty)
                begin
                    mem_we          = 1'b1;
                    res_status_next = lpht_pkg::STAT_OK;
                    res_slot_next   = lpht_pkg::slot_of(idx_reg);
                    state_next      = lpht_pkg::S_DONE;
                end
                else if (mode_reg && (lpht_pkg::home_of(rd_key) != idx_reg))
                begin
                    // new entry takes the slot; re-probe the occupant
                    mem_we     = 1'b1;
                    key_next   = rd_key;
                    pay_next   = rd_pay;
                    rslot_next = idx_reg;
                    disp_next  = 1'b1;
                    idx_next   = lpht_pkg::home_of(rd_key) + IDX_W'(1);
                    state_next = lpht_pkg::S_PROBE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = lpht_pkg::S_PROBE;
                end
            end

            lpht_pkg::S_PROBE:
            begin
                if (rd_empty)
                begin
                    mem_we          = 1'b1;
                    res_status_next = lpht_pkg::STAT_OK;
                    res_slot_next   = lpht_pkg::slot_of(disp_reg ? rslot_reg : idx_reg);
                    state_next      = lpht_pkg::S_DONE;
                end
                else if (last_probe)
                begin
                    res_status_next = lpht_pkg::STAT_FULL;
                    state_next      = lpht_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            lpht_pkg::S_SEARCH:
            begin
                if (rd_key == key_reg)
                begin
                    res_status_next = lpht_pkg::STAT_OK;
                    res_slot_next   = lpht_pkg::slot_of(idx_reg);
                    if (func_reg == lpht_pkg::FUNC_SEARCH)
                    begin
                        res_pay_next = rd_pay;
                        state_next   = lpht_pkg::S_DONE;
                    end
                    else
                    begin
                        hole_next  = idx_reg;
                        idx_next   = idx_reg + IDX_W'(1);
                        cnt_next   = '0;
                        state_next = lpht_pkg::S_SHIFT;
                    end
                end
                else if ((rd_empty && cnt_reg != '0) || last_probe)
                    state_next = lpht_pkg::S_DONE;
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            lpht_pkg::S_SHIFT:
            begin
                // hole holds stale data until cleared at the end of the walk
                mem_we    = 1'b1;
                mem_waddr = hole_reg;
                if (rd_empty || (lpht_pkg::home_of(rd_key) == idx_reg)
                    || (cnt_reg == CNT_W'(lpht_pkg::TABLE_SIZE)))
                begin
                    mem_wkey   = '0;
                    mem_wpay   = '0;
                    state_next = lpht_pkg::S_DONE;
                end
                else
                begin
                    mem_wkey  = rd_key;
                    mem_wpay  = rd_pay;
                    hole_next = idx_reg;
                    idx_next  = idx_reg + IDX_W'(1);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end

            lpht_pkg::S_DONE:
            begin
                if (out_load)
                    state_next = lpht_pkg::S_IDLE;
            end

            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lpht_pkg::S_IDLE;
            mode_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
            func_reg       <= '0;
            key_reg        <= '0;
            pay_reg        <= '0;
            idx_reg        <= '0;
            hole_reg       <= '0;
            rslot_reg      <= '0;
            cnt_reg        <= '0;
            disp_reg       <= 1'b0;
            res_status_reg <= '0;
            res_slot_reg   <= '0;
            res_pay_reg    <= '0;
            for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++)
            begin
                key_mem_reg[i] <= '0;
                pay_mem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            key_reg        <= key_next;
            pay_reg        <= pay_next;
            idx_reg        <= idx_next;
            hole_reg       <= hole_next;
            rslot_reg      <= rslot_next;
            cnt_reg        <= cnt_next;
            disp_reg       <= disp_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_pay_reg    <= res_pay_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (mem_we)
            begin
                key_mem_reg[mem_waddr] <= mem_wkey;
                pay_mem_reg[mem_waddr] <= mem_wpay;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg        <= res_status_reg;
            slot_reg          <= res_slot_reg;
            found_payload_reg <= res_pay_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign found_payload = found_payload_reg;

endmodule
